/* hdl/lptc_pkg.sv */
// Shared constants and types for the page translation cache.
`default_nettype none

package lptc_pkg;

   localparam int ENTRIES = 16;
   localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_W = $clog2(ENTRIES + 1);
   localparam int GRP = 4;
   localparam int NGRP = (ENTRIES + GRP - 1) / GRP;

   localparam int ADDR_W = 3;
   localparam int DATA_W = 32;
   localparam int SHIFT_W = 5;
   localparam int VA_W = 32;
   localparam int PID_W = 22;

   localparam logic [SHIFT_W-1:0] PAGE_SHIFT_RESET = 5'd12;
   localparam logic [ADDR_W-3:0] REG_PAGE_SHIFT = '0;

   localparam logic MODE_LOOKUP = 1'b0;
   localparam logic MODE_UPDATE = 1'b1;

   typedef struct packed {
      logic load;
      logic search;
      logic commit;
   } lptc_cmd_type;

endpackage

`default_nettype wire

/* hdl/lptc_if.sv */
// Request and response channel interfaces of the page translation cache.
`default_nettype none

interface lptc_req_if;
   logic        valid;
   logic        ready;
   logic        mode;
   logic [31:0] virt_addr;
   logic [21:0] proc_id;
   logic [31:0] mach_addr;

   modport source(output valid, mode, virt_addr, proc_id, mach_addr, input ready);
   modport sink(input valid, mode, virt_addr, proc_id, mach_addr, output ready);
endinterface

interface lptc_rsp_if;
   logic        valid;
   logic        ready;
   logic        hit;
   logic [31:0] phys_addr;
   logic        replaced;
   logic        evicted;

   modport source(output valid, hit, phys_addr, replaced, evicted, input ready);
   modport sink(input valid, hit, phys_addr, replaced, evicted, output ready);
endinterface

`default_nettype wire

/* hdl/lptc_ctrl.sv */
// Controller state machine that sequences accept, search and commit of each word.
`default_nettype none

module lptc_ctrl import lptc_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output lptc_cmd_type cmd
);

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_SEARCH = 2'd1;
   localparam logic [1:0] S_COMMIT = 2'd2;

   logic [1:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;
   logic       accept;
   logic       commit;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE) || ((state_ff == S_COMMIT) && out_free);
   assign accept    = req_valid && req_ready;
   assign commit    = (state_ff == S_COMMIT) && out_free;
   assign rsp_valid = rsp_valid_ff;

   assign cmd.load   = accept;
   assign cmd.search = (state_ff == S_SEARCH);
   assign cmd.commit = commit;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) state_in = S_SEARCH;
         end
         S_SEARCH: begin
            state_in = S_COMMIT;
         end
         S_COMMIT: begin
            if (out_free) state_in = accept ? S_SEARCH : S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      if (commit) rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
      else rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

/* hdl/lptc_datapath.sv */
// Entry storage, parallel tag compare, stamp minimum tree and result register.
`default_nettype none

module lptc_datapath import lptc_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  lptc_cmd_type       cmd,
   input  logic [SHIFT_W-1:0] page_shift,
   input  logic               req_mode,
   input  logic [VA_W-1:0]    req_virt_addr,
   input  logic [PID_W-1:0]   req_proc_id,
   input  logic [VA_W-1:0]    req_mach_addr,
   output logic               rsp_hit,
   output logic [VA_W-1:0]    rsp_phys_addr,
   output logic               rsp_replaced,
   output logic               rsp_evicted
);

   logic               mode_ff;
   logic [VA_W-1:0]    vaddr_ff;
   logic [PID_W-1:0]   pid_ff;
   logic [VA_W-1:0]    maddr_ff;

   logic [VA_W-1:0]    vpage_ff [ENTRIES];
   logic [VA_W-1:0]    vpage_in [ENTRIES];
   logic [VA_W-1:0]    mpage_ff [ENTRIES];
   logic [VA_W-1:0]    mpage_in [ENTRIES];
   logic [PID_W-1:0]   owner_ff [ENTRIES];
   logic [PID_W-1:0]   owner_in [ENTRIES];
   logic [31:0]        stamp_ff [ENTRIES];
   logic [31:0]        stamp_in [ENTRIES];
   logic [CNT_W-1:0]   fill_ff, fill_in;
   logic [31:0]        clock_ff, clock_in;

   logic               match_ff, match_in;
   logic [IDX_W-1:0]   match_idx_ff, match_idx_in;
   logic [VA_W-1:0]    found_phys_ff, found_phys_in;
   logic [31:0]        grp_stamp_ff [NGRP];
   logic [31:0]        grp_stamp_in [NGRP];
   logic [IDX_W-1:0]   grp_idx_ff [NGRP];
   logic [IDX_W-1:0]   grp_idx_in [NGRP];

   logic               hit_ff, hit_in;
   logic [VA_W-1:0]    phys_ff, phys_in;
   logic               repl_ff, repl_in;
   logic               evict_ff, evict_in;

   logic [VA_W-1:0]    omask;
   logic [VA_W-1:0]    vpage;
   logic [VA_W-1:0]    mpage_new;
   logic [ENTRIES-1:0] cand;
   logic [31:0]        victim_stamp;
   logic [IDX_W-1:0]   victim;
   logic               full;

   assign omask     = (32'd1 << page_shift) - 32'd1;
   assign vpage     = vaddr_ff & ~omask;
   assign mpage_new = maddr_ff & ~omask;
   assign full      = (fill_ff == CNT_W'(ENTRIES));

   always_comb begin
      for (int k = 0; k < ENTRIES; k++) begin
         if (mode_ff == MODE_UPDATE) begin
            cand[k] = (CNT_W'(k) < fill_ff) && (vpage_ff[k] == vpage) && (vaddr_ff != '0);
         end else begin
            cand[k] = (CNT_W'(k) < fill_ff) && (vpage_ff[k] == vpage) &&
                      (owner_ff[k] == pid_ff) && (mpage_ff[k] != '0);
         end
      end
   end

   // The lowest matching slot is the oldest inserted entry.
   always_comb begin
      match_in      = 1'b0;
      match_idx_in  = '0;
      found_phys_in = '0;
      for (int k = ENTRIES - 1; k >= 0; k--) begin
         if (cand[k]) begin
            match_in      = 1'b1;
            match_idx_in  = IDX_W'(k);
            found_phys_in = mpage_ff[k] | (vaddr_ff & omask);
         end
      end
   end

   always_comb begin
      for (int g = 0; g < NGRP; g++) begin
         grp_stamp_in[g] = stamp_ff[g * GRP];
         grp_idx_in[g]   = IDX_W'(g * GRP);
         for (int j = 1; j < GRP; j++) begin
            if (g * GRP + j < ENTRIES) begin
               if (stamp_ff[g * GRP + j] < grp_stamp_in[g]) begin
                  grp_stamp_in[g] = stamp_ff[g * GRP + j];
                  grp_idx_in[g]   = IDX_W'(g * GRP + j);
               end
            end
         end
      end
   end

   // Strict compare keeps the older entry when stamps are equal.
   always_comb begin
      victim_stamp = grp_stamp_ff[0];
      victim       = grp_idx_ff[0];
      for (int g = 1; g < NGRP; g++) begin
         if (grp_stamp_ff[g] < victim_stamp) begin
            victim_stamp = grp_stamp_ff[g];
            victim       = grp_idx_ff[g];
         end
      end
   end

   always_comb begin
      vpage_in = vpage_ff;
      mpage_in = mpage_ff;
      owner_in = owner_ff;
      stamp_in = stamp_ff;
      fill_in  = fill_ff;
      clock_in = clock_ff;
      hit_in   = hit_ff;
      phys_in  = phys_ff;
      repl_in  = repl_ff;
      evict_in = evict_ff;
      if (cmd.commit) begin
         clock_in = clock_ff + 32'd1;
         hit_in   = 1'b0;
         phys_in  = '0;
         repl_in  = 1'b0;
         evict_in = 1'b0;
         if (mode_ff == MODE_LOOKUP) begin
            hit_in = match_ff;
            if (match_ff) phys_in = found_phys_ff;
            for (int k = 0; k < ENTRIES; k++) begin
               if (match_ff && (IDX_W'(k) == match_idx_ff)) stamp_in[k] = clock_ff;
            end
         end else if (match_ff) begin
            repl_in = 1'b1;
            for (int k = 0; k < ENTRIES; k++) begin
               if (IDX_W'(k) == match_idx_ff) begin
                  stamp_in[k] = clock_ff;
                  owner_in[k] = pid_ff;
                  mpage_in[k] = mpage_new;
               end
            end
         end else if (full) begin
            evict_in = 1'b1;
            for (int k = 0; k < ENTRIES - 1; k++) begin
               if (IDX_W'(k) >= victim) begin
                  vpage_in[k] = vpage_ff[k + 1];
                  mpage_in[k] = mpage_ff[k + 1];
                  owner_in[k] = owner_ff[k + 1];
                  stamp_in[k] = stamp_ff[k + 1];
               end
            end
            vpage_in[ENTRIES - 1] = vpage;
            mpage_in[ENTRIES - 1] = mpage_new;
            owner_in[ENTRIES - 1] = pid_ff;
            stamp_in[ENTRIES - 1] = clock_ff;
         end else begin
            for (int k = 0; k < ENTRIES; k++) begin
               if (CNT_W'(k) == fill_ff) begin
                  vpage_in[k] = vpage;
                  mpage_in[k] = mpage_new;
                  owner_in[k] = pid_ff;
                  stamp_in[k] = clock_ff;
               end
            end
            fill_in = fill_ff + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mode_ff  <= req_mode;
         vaddr_ff <= req_virt_addr;
         pid_ff   <= req_proc_id;
         maddr_ff <= req_mach_addr;
      end
      if (cmd.search) begin
         match_ff      <= match_in;
         match_idx_ff  <= match_idx_in;
         found_phys_ff <= found_phys_in;
         grp_stamp_ff  <= grp_stamp_in;
         grp_idx_ff    <= grp_idx_in;
      end
      vpage_ff <= vpage_in;
      mpage_ff <= mpage_in;
      owner_ff <= owner_in;
      stamp_ff <= stamp_in;
      hit_ff   <= hit_in;
      phys_ff  <= phys_in;
      repl_ff  <= repl_in;
      evict_ff <= evict_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff  <= '0;
         clock_ff <= '0;
      end else begin
         fill_ff  <= fill_in;
         clock_ff <= clock_in;
      end
   end

   assign rsp_hit       = hit_ff;
   assign rsp_phys_addr = phys_ff;
   assign rsp_replaced  = repl_ff;
   assign rsp_evicted   = evict_ff;

endmodule

`default_nettype wire

/* hdl/lru_page_translation_cache.sv */
// Top level of the fully associative LRU page translation cache.
//
//   Port group   Direction   Content
//   req_bus      in          mode, virt_addr, proc_id, mach_addr
//   rsp_bus      out         hit, phys_addr, replaced, evicted
//   psel..pready csr         page_shift at byte address 0
//
// Each word passes a search step (parallel tag compare and the first level of the
// stamp minimum tree) and a commit step (final minimum and entry write); the next
// word can be accepted in its commit step. The result is registered at commit.
// Reset is synchronous and empties the cache; no clearing pass is needed.
// A stalled response holds the commit, and with it new words, until it is taken.
`default_nettype none

module lru_page_translation_cache import lptc_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   lptc_req_if.sink          req_bus,
   lptc_rsp_if.source        rsp_bus,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [DATA_W-1:0] pwdata,
   output logic [DATA_W-1:0] prdata,
   output logic              pready
);

   lptc_cmd_type       cmd;
   logic [SHIFT_W-1:0] page_shift_ff, page_shift_in;
   logic               csr_write;
   logic               csr_hit;

   assign pready    = 1'b1;
   assign csr_hit   = (paddr[ADDR_W-1:2] == REG_PAGE_SHIFT);
   assign csr_write = psel && penable && pwrite && pready;
   assign prdata    = csr_hit ? {{(DATA_W - SHIFT_W){1'b0}}, page_shift_ff} : '0;

   always_comb begin
      page_shift_in = page_shift_ff;
      if (csr_write && csr_hit) page_shift_in = pwdata[SHIFT_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         page_shift_ff <= PAGE_SHIFT_RESET;
      end else begin
         page_shift_ff <= page_shift_in;
      end
   end

   lptc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .cmd       (cmd)
   );

   lptc_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .page_shift    (page_shift_ff),
      .req_mode      (req_bus.mode),
      .req_virt_addr (req_bus.virt_addr),
      .req_proc_id   (req_bus.proc_id),
      .req_mach_addr (req_bus.mach_addr),
      .rsp_hit       (rsp_bus.hit),
      .rsp_phys_addr (rsp_bus.phys_addr),
      .rsp_replaced  (rsp_bus.replaced),
      .rsp_evicted   (rsp_bus.evicted)
   );

   a_search_blocks_accept : assert property (@(posedge clock) disable iff (reset)
      cmd.search |-> !req_bus.ready)
      else $error("word accepted during search");

   a_accept_then_search : assert property (@(posedge clock) disable iff (reset)
      (req_bus.valid && req_bus.ready) |=> cmd.search)
      else $error("accepted word not searched");

   a_commit_gives_response : assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> rsp_bus.valid)
      else $error("commit without response");

   a_response_only_after_commit : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_bus.valid) |-> $past(cmd.commit))
      else $error("response without commit");

endmodule

`default_nettype wire
